@@ rtl/core/rsm_pkg.sv @@
// Package for the random sample multiset: command codes, status codes, widths.
// No dependencies; used by every module of the block.
package rsm_pkg;

  localparam int ValW   = 32;
  localparam int StampW = 48;
  localparam int RndW   = 31;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Controls broadcast from the sequencer to every cell in a cycle.
  typedef struct packed {
    logic              shift;   // rotate the ring by one place
    logic              load;    // head cell takes a new entry
    logic              drop;    // tail entry discarded on shift
    logic [ValW-1:0]   val;
    logic [StampW-1:0] stamp;
  } cell_ctl_t;

endpackage

@@ rtl/core/rsm_cell.sv @@
// One slot of the ring: value, stamp and occupancy; passes them on when shifted.
// Depends on rsm_pkg.
module rsm_cell
  import rsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_i,
  input  cell_ctl_t         ctl_i,
  input  logic              prev_occ_i,
  input  logic [ValW-1:0]   prev_val_i,
  input  logic [StampW-1:0] prev_stamp_i,
  output logic              occ_o,
  output logic [ValW-1:0]   val_o,
  output logic [StampW-1:0] stamp_o
);

  logic              occ_q;
  logic [ValW-1:0]   val_q;
  logic [StampW-1:0] stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (ctl_i.shift) begin
      if (head_i && ctl_i.load) begin
        occ_q <= 1'b1;
      end else if (head_i && ctl_i.drop) begin
        occ_q <= 1'b0;
      end else begin
        occ_q <= prev_occ_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      if (head_i && ctl_i.load) begin
        val_q   <= ctl_i.val;
        stamp_q <= ctl_i.stamp;
      end else begin
        val_q   <= prev_val_i;
        stamp_q <= prev_stamp_i;
      end
    end
  end

  assign occ_o   = occ_q;
  assign val_o   = val_q;
  assign stamp_o = stamp_q;

endmodule

@@ rtl/core/rsm_ring.sv @@
// Ring of slot cells; the tail cell feeds the head so a full rotation is lossless.
// Depends on rsm_pkg and rsm_cell.
module rsm_ring
  import rsm_pkg::*;
#(
  parameter int Depth = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  output logic              tail_occ_o,
  output logic [ValW-1:0]   tail_val_o,
  output logic [StampW-1:0] tail_stamp_o
);

  logic              occ   [Depth];
  logic [ValW-1:0]   val   [Depth];
  logic [StampW-1:0] stamp [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    localparam int Prev = (g == 0) ? Depth - 1 : g - 1;
    rsm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .head_i       (g == 0),
      .ctl_i        (ctl_i),
      .prev_occ_i   (occ[Prev]),
      .prev_val_i   (val[Prev]),
      .prev_stamp_i (stamp[Prev]),
      .occ_o        (occ[g]),
      .val_o        (val[g]),
      .stamp_o      (stamp[g])
    );
  end

  assign tail_occ_o   = occ[Depth-1];
  assign tail_val_o   = val[Depth-1];
  assign tail_stamp_o = stamp[Depth-1];

endmodule

@@ rtl/core/random_sample_multiset.sv @@
// Random sample multiset: slots held in a rotating ring of cells, one cell per cycle.
// Every request makes one full rotation of the ring (the scan), and then its result is
// loaded into the output register. A remove that finds its value adds a second rotation
// (the fix); a sample runs a compare-subtract reduction before the scan. The next request
// is accepted only after the result load, which waits while the output register is full
// and not being read. Reset (asynchronous, active low) empties the set and the stamp counter.
module random_sample_multiset
  import rsm_pkg::*;
#(
  parameter int Capacity = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // cmd[1:0], value[33:2], random_word[64:34], zeros
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // flag[0], sample_value[32:1], status[34:33], zeros
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int PosW = $clog2(Capacity + 1);
  localparam int RemW = RndW + CntW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q;
  logic [ValW-1:0]    val_q;
  logic [RemW-1:0]    rem_q;     // remainder under reduction
  logic [RemW-1:0]    dsub_q;    // shifted divisor
  logic [5:0]         sh_q;
  logic [CntW-1:0]    cnt_q;
  logic [StampW-1:0]  nstamp_q;
  logic [PosW-1:0]    pos_q;     // ring rotation step
  logic               found_q;
  logic               seen_q;
  logic [StampW-1:0]  best_q;
  logic [PosW-1:0]    hole_q;
  logic [ValW-1:0]    pick_q;
  logic [ValW-1:0]    lastv_q;
  logic [StampW-1:0]  lasts_q;
  logic               ovalid_q;
  logic [34:0]        odata_q;
  logic [34:0]        odata_d;

  cell_ctl_t          ctl;
  logic               t_occ;
  logic [ValW-1:0]    t_val;
  logic [StampW-1:0]  t_stamp;

  rsm_ring #(.Depth(Capacity)) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .tail_occ_o   (t_occ),
    .tail_val_o   (t_val),
    .tail_stamp_o (t_stamp)
  );

  logic in_acc;
  logic out_free;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  // The output register may be reloaded when it is empty or being read in this cycle.
  assign out_free = !ovalid_q || m_axis_tready_i;

  // Slot index of the tail cell at step pos: ring holds slot k at cell k before
  // rotation, so the tail shows slot Capacity-1-pos.
  logic [PosW-1:0] tail_slot;
  assign tail_slot = PosW'(Capacity - 1) - pos_q;
  logic full;
  assign full = (cnt_q == CntW'(Capacity));

  // During the scan the ring rotates once; an insert replaces the entry of slot count as it
  // passes the head. The fix pass rotates again, writing the last entry into the hole.
  always_comb begin
    ctl       = '0;
    ctl.val   = val_q;
    ctl.stamp = nstamp_q;
    if (state_q == S_SCAN || state_q == S_FIX) begin
      ctl.shift = 1'b1;
      if (state_q == S_SCAN && cmd_q == CMD_INSERT && !full
          && tail_slot == PosW'(cnt_q)) begin
        ctl.load = 1'b1;
      end
      if (state_q == S_FIX && tail_slot == hole_q) begin
        ctl.load  = 1'b1;
        ctl.val   = lastv_q;
        ctl.stamp = lasts_q;
      end
      if (state_q == S_FIX && tail_slot == PosW'(cnt_q - 1'b1)
          && tail_slot != hole_q) begin
        ctl.drop = 1'b1;
      end
      if (state_q == S_FIX && tail_slot == PosW'(cnt_q - 1'b1)
          && tail_slot == hole_q) begin
        ctl.load = 1'b0;
        ctl.drop = 1'b1;
      end
    end
  end

  logic match;
  assign match = t_occ && (t_val == val_q) && (tail_slot < PosW'(cnt_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = (s_axis_tdata_i[1:0] == CMD_SAMPLE) ? S_MOD : S_SCAN;
      S_MOD:  if (sh_q == '0 || rem_q < RemW'(cnt_q)) state_d = S_SCAN;
      S_SCAN: if (pos_q == PosW'(Capacity - 1))
                state_d = (cmd_q == CMD_REMOVE && (found_q || match)) ? S_FIX : S_DONE;
      S_FIX:  if (pos_q == PosW'(Capacity - 1)) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      nstamp_q <= '0;
      ovalid_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: pos_q <= '0;
        S_SCAN, S_FIX: pos_q <= (pos_q == PosW'(Capacity - 1)) ? '0 : pos_q + 1'b1;
        S_DONE: if (out_free) begin
          if (cmd_q == CMD_INSERT && !full) begin
            cnt_q    <= cnt_q + 1'b1;
            nstamp_q <= nstamp_q + 1'b1;
          end
          if (cmd_q == CMD_REMOVE && found_q) cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    odata_d = '0;
    case (cmd_q)
      CMD_INSERT: begin
        odata_d[0]     = !full && !seen_q;
        odata_d[34:33] = full ? ST_FULL : ST_OK;
      end
      CMD_REMOVE: odata_d[0] = found_q;
      CMD_SAMPLE: begin
        if (cnt_q == '0) begin
          odata_d[34:33] = ST_EMPTY;
        end else begin
          odata_d[0]    = 1'b1;
          odata_d[32:1] = pick_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_acc) begin
        cmd_q   <= cmd_e'(s_axis_tdata_i[1:0]);
        val_q   <= s_axis_tdata_i[33:2];
        rem_q   <= RemW'(s_axis_tdata_i[64:34]);
        dsub_q  <= RemW'(cnt_q) << RndW;
        sh_q    <= 6'd31;
        found_q <= 1'b0;
        seen_q  <= 1'b0;
        best_q  <= '0;
        hole_q  <= '0;
      end
      S_MOD: begin
        dsub_q <= dsub_q >> 1;
        if (cnt_q == '0) begin
          rem_q <= '0;
          sh_q  <= '0;
        end else begin
          if (rem_q >= dsub_q) rem_q <= rem_q - dsub_q;
          if (sh_q != '0) sh_q <= sh_q - 1'b1;
        end
      end
      S_SCAN: begin
        if (match) seen_q <= 1'b1;
        if (match && (!found_q || t_stamp >= best_q)) begin
          found_q <= 1'b1;
          best_q  <= t_stamp;
          hole_q  <= tail_slot;
        end
        if (tail_slot == PosW'(rem_q)) pick_q <= t_val;
        if (tail_slot == PosW'(cnt_q - 1'b1)) begin
          lastv_q <= t_val;
          lasts_q <= t_stamp;
        end
      end
      S_DONE: if (out_free) odata_q <= odata_d;
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'b0, odata_q};

endmodule

@@ rtl/core/rsm_checker.sv @@
// Port-level checks for the random sample multiset, bound to the top level.
// Depends on rsm_pkg.
module rsm_checker
  import rsm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o) else $error("result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[34:33] != ST_RSVD) else $error("bad status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34:33] != ST_OK |-> !m_axis_tdata_o[0])
    else $error("flag with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o) else $error("second request");

endmodule

bind random_sample_multiset rsm_checker u_rsm_checker (.*);

@@ tb/sv/tb_top.sv @@
// Testbench for random_sample_multiset: random and directed requests checked against
// an in-bench model of the slot array. Depends on rsm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import rsm_pkg::*;

  localparam int Cap = 64;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [RndW-1:0] rnd;
    logic [ValW-1:0] val;
    cmd_e            cmd;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] sval;
    logic            flag;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  random_sample_multiset #(.Capacity(Cap)) u_top (.*);

  // Model state of the multiset.
  logic [ValW-1:0]   set_vals[Cap];
  logic [StampW-1:0] set_stamps[Cap];
  int unsigned       set_count = 0;
  logic [StampW-1:0] stamp_ctr = '0;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  function automatic res_t apply_request(req_t r);
    res_t o;
    bit hit;
    int unsigned hole;
    logic [StampW-1:0] best;
    o = '{status: ST_OK, sval: '0, flag: 1'b0};
    hit = 1'b0;
    hole = 0;
    best = '0;
    case (r.cmd)
      CMD_INSERT: begin
        if (set_count >= Cap) begin
          o.status = ST_FULL;
        end else begin
          for (int i = 0; i < set_count; i++) if (set_vals[i] == r.val) hit = 1'b1;
          set_vals[set_count] = r.val;
          set_stamps[set_count] = stamp_ctr;
          stamp_ctr++;
          set_count++;
          o.flag = !hit;
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < set_count; i++) begin
          if (set_vals[i] == r.val && (!hit || set_stamps[i] > best)) begin
            hit = 1'b1;
            best = set_stamps[i];
            hole = i;
          end
        end
        if (hit) begin
          set_vals[hole] = set_vals[set_count-1];
          set_stamps[hole] = set_stamps[set_count-1];
          set_count--;
          o.flag = 1'b1;
        end
      end
      CMD_SAMPLE: begin
        if (set_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.flag = 1'b1;
          o.sval = set_vals[r.rnd % set_count];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void add_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 4);
  endfunction

  // Values come from a small pool most of the time so duplicates are common.
  function automatic logic [ValW-1:0] pick_val();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 11) - 6;
    endcase
  endfunction

  function automatic logic [RndW-1:0] pick_rnd();
    case ($urandom_range(0, 3))
      0: return RndW'($urandom_range(0, 70));
      1: return {RndW{1'b1}};
      default: return RndW'($urandom() >> 1);
    endcase
  endfunction

  function automatic req_t mk(cmd_e c, logic [ValW-1:0] v, logic [RndW-1:0] r);
    req_t q;
    q.cmd = c;
    q.val = v;
    q.rnd = r;
    return q;
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned w;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed part: empty sample, absent remove, extremes, unused command.
    add_req(mk(CMD_SAMPLE, '0, '0));
    add_req(mk(CMD_REMOVE, 32'd5, '0));
    add_req(mk(CMD_NONE, 32'hffff_ffff, {RndW{1'b1}}));
    add_req(mk(CMD_INSERT, 32'h8000_0000, '0));
    add_req(mk(CMD_INSERT, 32'h7fff_ffff, '0));
    add_req(mk(CMD_INSERT, 32'h8000_0000, '0));
    add_req(mk(CMD_INSERT, 32'hffff_ffff, '0));
    add_req(mk(CMD_SAMPLE, '0, {RndW{1'b1}}));
    add_req(mk(CMD_SAMPLE, '0, 31'd2));
    add_req(mk(CMD_REMOVE, 32'h8000_0000, '0));
    add_req(mk(CMD_SAMPLE, '0, 31'd1));
    add_req(mk(CMD_REMOVE, 32'h8000_0000, '0));
    add_req(mk(CMD_REMOVE, 32'h8000_0000, '0));
    add_req(mk(CMD_REMOVE, 32'h7fff_ffff, '0));
    add_req(mk(CMD_REMOVE, 32'hffff_ffff, '0));
    // Fill to capacity, overflow, then sample the full set.
    for (int i = 0; i < Cap + 2; i++) add_req(mk(CMD_INSERT, pick_val(), '0));
    add_req(mk(CMD_SAMPLE, '0, 31'd63));
    add_req(mk(CMD_SAMPLE, '0, {RndW{1'b1}}));
    wait (pending_reqs.size() == 0 && !s_axis_tvalid_i && expected_res.size() == 0);
    // Random part in two phases, draining fully in between.
    for (int ph = 0; ph < 2; ph++) begin
      for (int n = 0; n < 250; n++) begin
        w = $urandom_range(0, 99);
        // Bias towards insert during the first phase and remove in the second.
        if (w < (ph == 0 ? 45 : 30)) begin
          add_req(mk(CMD_INSERT, pick_val(), pick_rnd()));
        end else if (w < 75) begin
          add_req(mk(CMD_REMOVE, pick_val(), pick_rnd()));
        end else if (w < 97) begin
          add_req(mk(CMD_SAMPLE, $urandom(), pick_rnd()));
        end else begin
          add_req(mk(CMD_NONE, $urandom(), pick_rnd()));
        end
      end
      wait (pending_reqs.size() == 0 && !s_axis_tvalid_i && expected_res.size() == 0);
    end
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Driver: one request at a time, gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && in_taken) begin
        s_axis_tvalid_i <= 1'b0;
        send_gap <= pick_gap();
      end else if (!s_axis_tvalid_i) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          s_axis_tdata_i <= {7'd0, pending_reqs.pop_front()};
          s_axis_tvalid_i <= 1'b1;
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 5) == 0) recv_gap <= pick_gap();
      end
    end
  end

  // The valid/ready pair is sampled at the rising edge, where the request is accepted.
  always @(posedge clk_i) begin
    res_t got, want;
    cycles <= cycles + 1;
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_res.insert(expected_res.size(), apply_request(req_t'(s_axis_tdata_i[64:0])));
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = res_t'(m_axis_tdata_o[34:0]);
      if (expected_res.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_res.pop_front();
        if (got.flag !== want.flag) begin
          errors = errors + 1;
          $display("%0t: flag expected %b actual %b", $time, want.flag, got.flag);
        end
        if (got.sval !== want.sval) begin
          errors = errors + 1;
          $display("%0t: sample_value expected %h actual %h", $time, want.sval, got.sval);
        end
        if (got.status !== want.status) begin
          errors = errors + 1;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
      end
    end
  end

  initial begin
    wait (stim_done || cycles >= CycleLimit);
    if (stim_done && errors == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ random_sample_multiset.f @@
rtl/core/rsm_pkg.sv
rtl/core/rsm_cell.sv
rtl/core/rsm_ring.sv
rtl/core/random_sample_multiset.sv
rtl/core/rsm_checker.sv
tb/sv/tb_top.sv
